FILE: hw/rtl/sv39ptm_pkg.sv
package sv39ptm_pkg;

  localparam int TABLE_PAGES_DEF   = 16;
  localparam int ENTRIES_PER_TABLE = 512;

  localparam int VPN_W  = 27;
  localparam int PPN_W  = 44;
  localparam int CNT_W  = 16;
  localparam int PERM_W = 4;
  localparam int TIU_W  = 5;

  localparam logic [PERM_W-1:0] PTR_FLAGS = 4'b0001;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_root;
    logic chk_root;
    logic chk_mid;
    logic wr_leaf;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_empty;
    logic need_alloc;
    logic pool_full;
    logic last_page;
  } sts_t;

endpackage

FILE: hw/rtl/sv39_page_table_mapper_unit.sv
// channel | handshake              | payload
// in      | start, busy            | in_virt_page, in_phys_page, in_page_count, in_perm_bits
// out     | out_valid (strobe)     | out_status, out_pages_written, out_tables_in_use
// cfg     | cfg_we                 | cfg_wdata (pool_base_ppn)
//
// After reset the table memory is cleared one entry a cycle, all TABLE_PAGES*512 entries
// (8192 at the default); busy stays high during the sweep, cfg writes are taken.
// Each page goes through root read, root check, level-1 check and leaf write, since each
// pointer level needs one registered read of the single-read-port table memory.
// The strobe follows the last leaf write, a check that finds the pool full, or, for an
// empty run, the accept; busy drops the cycle after it. The receiver cannot stall.
module sv39_page_table_mapper_unit #(
  parameter int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sv39ptm_pkg::VPN_W-1:0]   in_virt_page,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   in_phys_page,
  input  logic [sv39ptm_pkg::CNT_W-1:0]   in_page_count,
  input  logic [sv39ptm_pkg::PERM_W-1:0]  in_perm_bits,
  output logic                            out_valid,
  output logic                            out_status,
  output logic [sv39ptm_pkg::CNT_W-1:0]   out_pages_written,
  output logic [sv39ptm_pkg::TIU_W-1:0]   out_tables_in_use,
  input  logic                            cfg_we,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   cfg_wdata
);

  sv39ptm_pkg::cmd_t cmd;
  sv39ptm_pkg::sts_t sts;

  sv39ptm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  sv39ptm_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_virt_page      (in_virt_page),
    .in_phys_page      (in_phys_page),
    .in_page_count     (in_page_count),
    .in_perm_bits      (in_perm_bits),
    .out_status        (out_status),
    .out_pages_written (out_pages_written),
    .out_tables_in_use (out_tables_in_use)
  );

endmodule

FILE: hw/rtl/sv39ptm_ctrl.sv
module sv39ptm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output sv39ptm_pkg::cmd_t  cmd,
  input  sv39ptm_pkg::sts_t  sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_CHK2  = 3'd3;
  localparam logic [2:0] S_CHK1  = 3'd4;
  localparam logic [2:0] S_LEAF  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.req_empty ? S_DONE : S_RD2;
        end
      end
      S_RD2: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_CHK2;
      end
      S_CHK2: begin
        cmd.chk_root = 1'b1;
        state_nxt    = (sts.need_alloc && sts.pool_full) ? S_DONE : S_CHK1;
      end
      S_CHK1: begin
        cmd.chk_mid = 1'b1;
        state_nxt   = (sts.need_alloc && sts.pool_full) ? S_DONE : S_LEAF;
      end
      S_LEAF: begin
        cmd.wr_leaf = 1'b1;
        state_nxt   = sts.last_page ? S_DONE : S_RD2;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held past one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

FILE: hw/rtl/sv39ptm_dp.sv
module sv39ptm_dp #(
  parameter int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sv39ptm_pkg::cmd_t               cmd,
  output sv39ptm_pkg::sts_t               sts,
  input  logic                            cfg_we,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   cfg_wdata,
  input  logic [sv39ptm_pkg::VPN_W-1:0]   in_virt_page,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   in_phys_page,
  input  logic [sv39ptm_pkg::CNT_W-1:0]   in_page_count,
  input  logic [sv39ptm_pkg::PERM_W-1:0]  in_perm_bits,
  output logic                            out_status,
  output logic [sv39ptm_pkg::CNT_W-1:0]   out_pages_written,
  output logic [sv39ptm_pkg::TIU_W-1:0]   out_tables_in_use
);

  localparam int IW    = $clog2(TABLE_PAGES);
  localparam int FW    = $clog2(TABLE_PAGES + 1);
  localparam int IXW   = $clog2(sv39ptm_pkg::ENTRIES_PER_TABLE);
  localparam int AW    = IW + IXW;
  localparam int DEPTH = TABLE_PAGES * sv39ptm_pkg::ENTRIES_PER_TABLE;
  localparam int PW    = sv39ptm_pkg::PPN_W;
  localparam int FLW   = sv39ptm_pkg::PERM_W;
  localparam int CW    = sv39ptm_pkg::CNT_W;
  localparam int VW    = sv39ptm_pkg::VPN_W;
  localparam int EW    = PW + FLW;

  logic [EW-1:0]  tbl_mem [0:DEPTH-1];
  logic [EW-1:0]  rd_data_r;

  logic [PW-1:0]  base_r,     base_nxt;
  logic [FW-1:0]  free_r,     free_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [VW-1:0]  vpage_r,    vpage_nxt;
  logic [PW-1:0]  ppage_r,    ppage_nxt;
  logic [FLW-1:0] perm_r,     perm_nxt;
  logic [CW-1:0]  remain_r,   remain_nxt;
  logic [CW-1:0]  done_r,     done_nxt;
  logic           fail_r,     fail_nxt;
  logic [IW-1:0]  mid_r,      mid_nxt;
  logic [IW-1:0]  leaf_r,     leaf_nxt;

  logic [IXW-1:0] i2, i1, i0;
  logic [PW-1:0]  rd_ppn;
  logic           rd_v;
  logic [PW-1:0]  rel;
  logic           ptr_ok;
  logic           pool_full;
  logic [IW-1:0]  child;
  logic           chk;
  logic           alloc;
  logic [PW-1:0]  fresh_ppn;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [EW-1:0]  wr_data;

  assign i2 = vpage_r[3*IXW-1:2*IXW];
  assign i1 = vpage_r[2*IXW-1:IXW];
  assign i0 = vpage_r[IXW-1:0];

  assign rd_ppn    = rd_data_r[EW-1:FLW];
  assign rd_v      = rd_data_r[0];
  assign rel       = rd_ppn - base_r;
  assign ptr_ok    = rd_v && (rel < PW'(TABLE_PAGES));
  assign pool_full = (free_r == FW'(TABLE_PAGES));
  assign child     = ptr_ok ? rel[IW-1:0] : free_r[IW-1:0];
  assign chk       = cmd.chk_root || cmd.chk_mid;
  assign alloc     = chk && !ptr_ok && !pool_full;
  assign fresh_ppn = base_r + PW'(free_r);

  assign rd_en   = cmd.rd_root || cmd.chk_root;
  assign rd_addr = cmd.rd_root ? {IW'(0), i2} : {child, i1};

  always_comb begin
    wr_en = cmd.clear || alloc || cmd.wr_leaf;
    if (cmd.clear) begin
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (cmd.wr_leaf) begin
      wr_addr = {leaf_r, i0};
      wr_data = {ppage_r, perm_r};
    end else if (cmd.chk_root) begin
      wr_addr = {IW'(0), i2};
      wr_data = {fresh_ppn, sv39ptm_pkg::PTR_FLAGS};
    end else begin
      wr_addr = {mid_r, i1};
      wr_data = {fresh_ppn, sv39ptm_pkg::PTR_FLAGS};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[rd_addr];
    end
  end

  always_comb begin
    base_nxt     = base_r;
    free_nxt     = free_r;
    clr_addr_nxt = clr_addr_r;
    vpage_nxt    = vpage_r;
    ppage_nxt    = ppage_r;
    perm_nxt     = perm_r;
    remain_nxt   = remain_r;
    done_nxt     = done_r;
    fail_nxt     = fail_r;
    mid_nxt      = mid_r;
    leaf_nxt     = leaf_r;
    if (cfg_we) begin
      base_nxt = cfg_wdata;
    end
    if (cmd.clear) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
    if (cmd.load) begin
      vpage_nxt  = in_virt_page;
      ppage_nxt  = in_phys_page;
      perm_nxt   = in_perm_bits;
      remain_nxt = in_page_count;
      done_nxt   = '0;
      fail_nxt   = 1'b0;
    end
    if (cmd.chk_root) begin
      mid_nxt = child;
    end
    if (cmd.chk_mid) begin
      leaf_nxt = child;
    end
    if (alloc) begin
      free_nxt = free_r + 1'b1;
    end
    if (chk && !ptr_ok && pool_full) begin
      fail_nxt = 1'b1;
    end
    if (cmd.wr_leaf) begin
      done_nxt   = done_r + 1'b1;
      remain_nxt = remain_r - 1'b1;
      vpage_nxt  = vpage_r + 1'b1;
      ppage_nxt  = ppage_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      free_r     <= FW'(1);
      clr_addr_r <= '0;
    end else begin
      base_r     <= base_nxt;
      free_r     <= free_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpage_r  <= vpage_nxt;
    ppage_r  <= ppage_nxt;
    perm_r   <= perm_nxt;
    remain_r <= remain_nxt;
    done_r   <= done_nxt;
    fail_r   <= fail_nxt;
    mid_r    <= mid_nxt;
    leaf_r   <= leaf_nxt;
  end

  assign sts.clear_last = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.req_empty  = (in_page_count == '0);
  assign sts.need_alloc = !ptr_ok;
  assign sts.pool_full  = pool_full;
  assign sts.last_page  = (remain_r == CW'(1));

  assign out_status        = fail_r;
  assign out_pages_written = done_r;
  assign out_tables_in_use = sv39ptm_pkg::TIU_W'(free_r);

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r <= FW'(TABLE_PAGES)) && (free_r != '0))
    else $error("free table counter out of range");

  a_leaf_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_leaf |=> (done_r == CW'($past(done_r) + 1'b1)))
    else $error("leaf write not counted");

endmodule

FILE: tb/sv39_page_table_mapper_unit_chk.sv
`timescale 1ns / 100ps
module sv39_page_table_mapper_unit_chk #(
  parameter int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [sv39ptm_pkg::VPN_W-1:0]   in_virt_page,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   in_phys_page,
  input  logic [sv39ptm_pkg::CNT_W-1:0]   in_page_count,
  input  logic [sv39ptm_pkg::PERM_W-1:0]  in_perm_bits,
  input  logic                            out_valid,
  input  logic                            out_status,
  input  logic [sv39ptm_pkg::CNT_W-1:0]   out_pages_written,
  input  logic [sv39ptm_pkg::TIU_W-1:0]   out_tables_in_use,
  input  logic                            cfg_we,
  input  logic [sv39ptm_pkg::PPN_W-1:0]   cfg_wdata,
  output int                              errors,
  output int                              outstanding
);

  localparam int PW    = sv39ptm_pkg::PPN_W;
  localparam int EPT   = sv39ptm_pkg::ENTRIES_PER_TABLE;
  localparam int SLOTS = TABLE_PAGES * EPT;

  typedef struct packed {
    logic                            status;
    logic [sv39ptm_pkg::CNT_W-1:0]   written;
    logic [sv39ptm_pkg::TIU_W-1:0]   tables;
  } map_result_t;

  logic [63:0]   pte_mem [SLOTS];
  int unsigned   next_table;
  logic [PW-1:0] pool_base;
  map_result_t   result_q[$];
  int            fail_count = 0;

  // follow a pointer entry, or allocate a fresh table over an unusable one; fail when the pool is full
  function automatic bit walk_level(input int unsigned tbl, input logic [8:0] slot,
                                    output int unsigned child);
    logic [63:0]   pte;
    logic [PW-1:0] rel;
    logic [PW-1:0] fresh_ppn;
    int unsigned   pos;
    pos = tbl * EPT + 32'(slot);
    pte = pte_mem[pos];
    rel = pte[53:10] - pool_base;
    if (pte[0] && rel < PW'(TABLE_PAGES)) begin
      child = 32'(rel);
      return 1'b1;
    end
    if (next_table >= TABLE_PAGES) return 1'b0;
    fresh_ppn = pool_base + PW'(next_table);
    pte_mem[pos] = {10'b0, fresh_ppn, 6'b0, sv39ptm_pkg::PTR_FLAGS};
    child = next_table;
    next_table++;
    return 1'b1;
  endfunction

  function automatic map_result_t map_run(input logic [sv39ptm_pkg::VPN_W-1:0] vpage_in,
                                          input logic [PW-1:0] ppage_in,
                                          input logic [sv39ptm_pkg::CNT_W-1:0] count,
                                          input logic [sv39ptm_pkg::PERM_W-1:0] perm);
    logic [sv39ptm_pkg::VPN_W-1:0] vpage;
    logic [PW-1:0]                 ppage;
    int unsigned                   mid;
    int unsigned                   leaf;
    map_result_t                   r;
    vpage = vpage_in;
    ppage = ppage_in;
    r = '0;
    while (r.written < count && !r.status) begin
      if (!walk_level(0, vpage[26:18], mid) || !walk_level(mid, vpage[17:9], leaf)) begin
        r.status = 1'b1;
      end else begin
        pte_mem[leaf * EPT + 32'(vpage[8:0])] = {10'b0, ppage, 6'b0, perm};
        r.written = r.written + 1'b1;
        vpage = vpage + 1'b1;
        ppage = ppage + 1'b1;
      end
    end
    r.tables = next_table[sv39ptm_pkg::TIU_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      foreach (pte_mem[i]) pte_mem[i] = '0;
      next_table = 1;
      pool_base = '0;
      result_q.delete();
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none pending: status %0d pages_written %0d",
                   $time, out_status, out_pages_written);
          $display("%0t: tables_in_use %0d", $time, out_tables_in_use);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_pages_written !== want.written) begin
            $display("%0t: pages_written expected %0d, got %0d",
                     $time, want.written, out_pages_written);
            fail_count++;
          end
          if (out_tables_in_use !== want.tables) begin
            $display("%0t: tables_in_use expected %0d, got %0d",
                     $time, want.tables, out_tables_in_use);
            fail_count++;
          end
        end
      end
      if (cfg_we) pool_base = cfg_wdata;
      if (start && !busy) begin
        result_q.push_back(map_run(in_virt_page, in_phys_page, in_page_count, in_perm_bits));
      end
    end
    errors <= fail_count;
    outstanding <= result_q.size();
  end

endmodule

FILE: tb/sv39_page_table_mapper_unit_tb.sv
`timescale 1ns / 100ps
module sv39_page_table_mapper_unit_tb;

  localparam int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF;
  localparam int STALL_LIMIT = 1000000;

  localparam logic [sv39ptm_pkg::PPN_W-1:0] PPN_TOP   = '1;
  localparam logic [sv39ptm_pkg::PPN_W-1:0] BASE_MAIN = PPN_TOP - 44'd2;
  localparam logic [sv39ptm_pkg::PPN_W-1:0] BASE_ALT  = 44'h00abcdef123;
  localparam logic [sv39ptm_pkg::VPN_W-1:0] VPN_TOP   = '1;
  // root slot 5, level-1 slots 506..511: six leaf tables, then root slot 6
  localparam logic [sv39ptm_pkg::VPN_W-1:0] HOT_VPAGE = 27'h017f400;
  localparam int HOT_SPAN = 3072;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [sv39ptm_pkg::VPN_W-1:0]   in_virt_page;
  logic [sv39ptm_pkg::PPN_W-1:0]   in_phys_page;
  logic [sv39ptm_pkg::CNT_W-1:0]   in_page_count;
  logic [sv39ptm_pkg::PERM_W-1:0]  in_perm_bits;
  logic                            out_valid;
  logic                            out_status;
  logic [sv39ptm_pkg::CNT_W-1:0]   out_pages_written;
  logic [sv39ptm_pkg::TIU_W-1:0]   out_tables_in_use;
  logic                            cfg_we;
  logic [sv39ptm_pkg::PPN_W-1:0]   cfg_wdata;
  int                              errors;
  int                              outstanding;
  int                              quiet_cycles = 0;

  sv39_page_table_mapper_unit #(.TABLE_PAGES(TABLE_PAGES)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_virt_page      (in_virt_page),
    .in_phys_page      (in_phys_page),
    .in_page_count     (in_page_count),
    .in_perm_bits      (in_perm_bits),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_pages_written (out_pages_written),
    .out_tables_in_use (out_tables_in_use),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  sv39_page_table_mapper_unit_chk #(.TABLE_PAGES(TABLE_PAGES)) map_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_virt_page      (in_virt_page),
    .in_phys_page      (in_phys_page),
    .in_page_count     (in_page_count),
    .in_perm_bits      (in_perm_bits),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_pages_written (out_pages_written),
    .out_tables_in_use (out_tables_in_use),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .errors            (errors),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("sv39_page_table_mapper_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_pool_base(input logic [sv39ptm_pkg::PPN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the item until taken, then maybe drop start for a random gap
  task automatic map_item(input logic [sv39ptm_pkg::VPN_W-1:0] vpage,
                          input logic [sv39ptm_pkg::PPN_W-1:0] ppage,
                          input logic [sv39ptm_pkg::CNT_W-1:0] count,
                          input logic [sv39ptm_pkg::PERM_W-1:0] perm,
                          input int idle_pct);
    in_virt_page <= vpage;
    in_phys_page <= ppage;
    in_page_count <= count;
    in_perm_bits <= perm;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic random_items(input int n, input int idle_pct);
    logic [sv39ptm_pkg::VPN_W-1:0]  vpage;
    logic [sv39ptm_pkg::CNT_W-1:0]  count;
    logic [sv39ptm_pkg::PERM_W-1:0] perm;
    logic [63:0]                    wide;
    int                             pick;
    int                             k;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) vpage = sv39ptm_pkg::VPN_W'(HOT_VPAGE + $urandom_range(HOT_SPAN - 1));
      else if (pick < 80) vpage = VPN_TOP - sv39ptm_pkg::VPN_W'($urandom_range(511));
      else vpage = sv39ptm_pkg::VPN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) count = '0;
      else if (pick < 85) count = sv39ptm_pkg::CNT_W'($urandom_range(1, 8));
      else if (pick < 97) count = sv39ptm_pkg::CNT_W'($urandom_range(9, 64));
      else count = sv39ptm_pkg::CNT_W'($urandom_range(65, 600));
      wide = {$urandom, $urandom};
      perm = sv39ptm_pkg::PERM_W'($urandom_range(15));
      map_item(vpage, wide[sv39ptm_pkg::PPN_W-1:0], count, perm, idle_pct);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_virt_page <= '0;
    in_phys_page <= '0;
    in_page_count <= '0;
    in_perm_bits <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_pool_base(BASE_MAIN);

    map_item(27'h0, 44'h0, 16'd0, 4'h0, 21);
    map_item(27'h0, 44'h0, 16'd1, 4'h0, 21);
    map_item(VPN_TOP - 27'd1, PPN_TOP - 44'd1, 16'd3, 4'hf, 21);
    map_item(27'd5, 44'h5a5a5a5a5a5, 16'd4, 4'b1110, 21);
    map_item(27'h1ff, 44'h0123456789a, 16'd2, 4'b0011, 21);
    drain_results();
    write_pool_base(BASE_ALT);
    map_item(27'h0, 44'ha5a5a5a5a5a, 16'd1, 4'b1011, 21);
    drain_results();
    write_pool_base(BASE_MAIN);
    map_item(HOT_VPAGE, 44'h00000001000, 16'hffff, 4'hf, 21);
    map_item(27'h0, 44'h00000000010, 16'd1, 4'h1, 21);
    map_item(HOT_VPAGE + HOT_SPAN - 2, 44'h7ffffffffff, 16'd10, 4'h7, 21);
    map_item(27'h4000000, 44'h0, 16'd1, 4'h1, 21);

    random_items(500, 21);
    drain_results();
    write_pool_base('0);
    random_items(20, 0);
    drain_results();
    write_pool_base(BASE_MAIN);
    random_items(500, 52);
    drain_results();
    write_pool_base(PPN_TOP);
    random_items(20, 0);
    drain_results();
    write_pool_base(BASE_MAIN);
    random_items(500, 0);
    drain_results();
    write_pool_base(BASE_MAIN - 44'd2);
    random_items(20, 0);
    drain_results();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("sv39_page_table_mapper_unit_tb passed");
    end else begin
      $display("sv39_page_table_mapper_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sv39ptm_pkg.sv
hw/rtl/sv39ptm_ctrl.sv
hw/rtl/sv39ptm_dp.sv
hw/rtl/sv39_page_table_mapper_unit.sv
tb/sv39_page_table_mapper_unit_chk.sv
tb/sv39_page_table_mapper_unit_tb.sv
